// File: sv/tdp_pkg.sv
package tdp_pkg;

  // Operand width and derived datapath widths
  localparam int unsigned WIDTH = 32;
  localparam int unsigned DIV_W = WIDTH / 2 + 1;
  localparam int unsigned SQ_W  = WIDTH + 2;
  localparam int unsigned REM_W = DIV_W + 1;
  localparam int unsigned CNT_W = $clog2(WIDTH);

  localparam logic [DIV_W-1:0] FIRST_DIV = DIV_W'(3);
  localparam logic [SQ_W-1:0]  FIRST_SQ  = SQ_W'(9);
  localparam logic [CNT_W-1:0] LAST_BIT  = CNT_W'(WIDTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_COMPARE,
    S_DIVIDE,
    S_TEST,
    S_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic start_div;
    logic div_step;
    logic next_div;
    logic verdict_we;
    logic verdict;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic trivial;
    logic trivial_prime;
    logic sq_gt;
    logic div_last;
    logic rem_zero;
    logic out_free;
  } status_t;

endpackage

// File: sv/tdp_req_if.sv
interface tdp_req_if;
  logic                        valid;
  logic                        ready;
  logic [tdp_pkg::WIDTH-1:0]   value;
  logic                        mode;

  modport source (output valid, output value, output mode, input ready);
  modport sink   (input valid, input value, input mode, output ready);
endinterface

// File: sv/tdp_rsp_if.sv
interface tdp_rsp_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

// File: sv/tdp_ctrl.sv
module tdp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  tdp_pkg::status_t status_i,
  output tdp_pkg::cmd_t    cmd_o
);

  tdp_pkg::state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tdp_pkg::S_IDLE: begin
        if (req_valid_i) state_d = tdp_pkg::S_CLASSIFY;
      end
      tdp_pkg::S_CLASSIFY: begin
        state_d = status_i.trivial ? tdp_pkg::S_FINISH : tdp_pkg::S_COMPARE;
      end
      tdp_pkg::S_COMPARE: begin
        state_d = status_i.sq_gt ? tdp_pkg::S_FINISH : tdp_pkg::S_DIVIDE;
      end
      tdp_pkg::S_DIVIDE: begin
        if (status_i.div_last) state_d = tdp_pkg::S_TEST;
      end
      tdp_pkg::S_TEST: begin
        state_d = status_i.rem_zero ? tdp_pkg::S_FINISH : tdp_pkg::S_COMPARE;
      end
      tdp_pkg::S_FINISH: begin
        if (status_i.out_free) state_d = tdp_pkg::S_IDLE;
      end
      default: state_d = tdp_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      tdp_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      tdp_pkg::S_CLASSIFY: begin
        cmd_o.verdict_we = status_i.trivial;
        cmd_o.verdict    = status_i.trivial_prime;
      end
      tdp_pkg::S_COMPARE: begin
        cmd_o.verdict_we = status_i.sq_gt;
        cmd_o.verdict    = 1'b1;
        cmd_o.start_div  = !status_i.sq_gt;
      end
      tdp_pkg::S_DIVIDE: begin
        cmd_o.div_step = 1'b1;
      end
      tdp_pkg::S_TEST: begin
        cmd_o.verdict_we = status_i.rem_zero;
        cmd_o.verdict    = 1'b0;
        cmd_o.next_div   = !status_i.rem_zero;
      end
      tdp_pkg::S_FINISH: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// File: sv/tdp_datapath.sv
module tdp_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [tdp_pkg::WIDTH-1:0] value_i,
  input  logic                      mode_i,
  input  tdp_pkg::cmd_t             cmd_i,
  output tdp_pkg::status_t          status_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      is_prime_o
);

  logic [tdp_pkg::WIDTH-1:0] value_q;
  logic                      mode_q;
  logic [tdp_pkg::DIV_W-1:0] div_q, div_d;
  logic [tdp_pkg::SQ_W-1:0]  sq_q, sq_d;
  logic [tdp_pkg::REM_W-1:0] rem_q, rem_d;
  logic [tdp_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      verdict_q;
  logic                      out_valid_q;
  logic                      is_prime_q;

  logic [tdp_pkg::REM_W-1:0] rem_shift;
  logic [tdp_pkg::REM_W-1:0] div_ext;
  logic                      neg, below_two, two_or_three;

  // Classify the held value
  assign neg          = mode_q & value_q[tdp_pkg::WIDTH-1];
  assign below_two    = (value_q < tdp_pkg::WIDTH'(2));
  assign two_or_three = (value_q == tdp_pkg::WIDTH'(2)) || (value_q == tdp_pkg::WIDTH'(3));

  // One restoring remainder step per cycle, msb first
  assign rem_shift = {rem_q[tdp_pkg::REM_W-2:0], value_q[cnt_q]};
  assign div_ext   = {1'b0, div_q};

  always_comb begin
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.start_div) begin
      rem_d = '0;
      cnt_d = tdp_pkg::LAST_BIT;
    end else if (cmd_i.div_step) begin
      rem_d = (rem_shift >= div_ext) ? rem_shift - div_ext : rem_shift;
      cnt_d = cnt_q - tdp_pkg::CNT_W'(1);
    end
  end

  // Advance divisor and its square: (d+2)^2 = d^2 + 4d + 4
  always_comb begin
    div_d = div_q;
    sq_d  = sq_q;
    if (cmd_i.load) begin
      div_d = tdp_pkg::FIRST_DIV;
      sq_d  = tdp_pkg::FIRST_SQ;
    end else if (cmd_i.next_div) begin
      div_d = div_q + tdp_pkg::DIV_W'(2);
      sq_d  = sq_q + tdp_pkg::SQ_W'({div_q, 2'b00}) + tdp_pkg::SQ_W'(4);
    end
  end

  // Hold operand and search registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q    <= '0;
      mode_q     <= 1'b0;
      div_q      <= tdp_pkg::FIRST_DIV;
      sq_q       <= tdp_pkg::FIRST_SQ;
      rem_q      <= '0;
      cnt_q      <= '0;
      verdict_q  <= 1'b0;
      is_prime_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        value_q <= value_i;
        mode_q  <= mode_i;
      end
      div_q <= div_d;
      sq_q  <= sq_d;
      rem_q <= rem_d;
      cnt_q <= cnt_d;
      if (cmd_i.verdict_we) verdict_q <= cmd_i.verdict;
      if (cmd_i.load_out)   is_prime_q <= verdict_q;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.trivial       = neg | below_two | two_or_three | !value_q[0];
  assign status_o.trivial_prime = !neg & two_or_three;
  assign status_o.sq_gt         = (sq_q > {2'b00, value_q});
  assign status_o.div_last      = (cnt_q == '0);
  assign status_o.rem_zero      = (rem_q == '0);
  assign status_o.out_free      = !out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

endmodule

// File: sv/trial_division_prime_test_unit.sv
// Trial-division primality test for WIDTH-bit values (32 by default).
//
// Request channel req_i carries value and mode (0 unsigned, 1 two's
// complement); response channel rsp_o carries is_prime, one response per
// request, in order. Both use valid/ready; a transfer happens on a rising
// edge with valid and ready high.
// One request is worked on at a time; req_i.ready is high only while idle.
// Values settled by classification (negative, below 2, 2, 3, even) pass
// from the classify state through the finish state to the output
// register. Odd values run a search over odd divisors from d = 3 upward
// while d*d <= value; each divisor takes a compare step, a restoring
// remainder unit at one bit per cycle and a test step; a 32-bit prime
// near 2^32 needs about 32768 divisors.
// The response sits in an output register: a stalled receiver holds it
// there and the next request is still taken and searched; a finished
// search waits until the register is free.
// Reset (rst_ni, asynchronous, active low) returns the controller to idle
// and drops any pending response.
module trial_division_prime_test_unit (
  input  logic clk_i,
  input  logic rst_ni,
  tdp_req_if.sink   req_i,
  tdp_rsp_if.source rsp_o
);

  tdp_pkg::cmd_t    cmd;
  tdp_pkg::status_t status;

  tdp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tdp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (req_i.value),
    .mode_i      (req_i.mode),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .is_prime_o  (rsp_o.is_prime)
  );

endmodule
